// ----- src/lfu_pkg.sv -----
// Shared constants, types and widths for the LFU page replacement block.
package lfu_pkg;

   localparam int FRAMES     = 8;
   localparam int PAGE_BITS  = 16;
   localparam int COUNT_BITS = 16;
   localparam int IDX_BITS   = (FRAMES > 1) ? $clog2(FRAMES) : 1;

   localparam int PAGE_NUMBER_W  = 16;
   localparam int FRAME_INDEX_W  = 3;
   localparam int EVICTED_PAGE_W = 16;

   localparam int CFG_BITS      = 4;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   // register select is paddr bit 2 (one register at byte address 0)
   localparam logic REG_FRAMES_IN_USE = 1'b0;

   localparam logic [CFG_BITS-1:0] CFG_RESET = CFG_BITS'((FRAMES < 15) ? FRAMES : 15);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   typedef struct packed {
      logic                  valid;
      logic [PAGE_BITS-1:0]  page;
      logic                  hit;
      logic [IDX_BITS-1:0]   hit_idx;
      logic                  empty;
      logic [IDX_BITS-1:0]   empty_idx;
      logic                  min_set;
      logic [COUNT_BITS-1:0] min_cnt;
      logic [IDX_BITS-1:0]   min_idx;
      logic [PAGE_BITS-1:0]  min_page;
   } search_type;

   typedef struct packed {
      logic                 en;
      logic                 fill;
      logic [IDX_BITS-1:0]  idx;
      logic [PAGE_BITS-1:0] page;
   } update_type;

endpackage

// ----- src/lfu_cell.sv -----
// One frame cell: holds page, valid and use count, folds itself into the passing search token.
module lfu_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [lfu_pkg::IDX_BITS-1:0] cell_idx,
   input  logic                        cell_on,
   input  lfu_pkg::search_type         tok_in,
   output lfu_pkg::search_type         tok_out,
   input  lfu_pkg::update_type         upd
);
   import lfu_pkg::*;

   logic [PAGE_BITS-1:0]  page_ff;
   logic                  valid_ff;
   logic [COUNT_BITS-1:0] cnt_ff;
   search_type            tok_ff;
   search_type            tok_in_c;
   logic                  upd_here;

   assign upd_here = upd.en && (upd.idx == cell_idx);

   always_comb begin
      tok_in_c       = tok_in;
      tok_in_c.valid = tok_in.valid & cell_on;
      if (!tok_in.hit && valid_ff && (page_ff == tok_in.page)) begin
         tok_in_c.hit     = 1'b1;
         tok_in_c.hit_idx = cell_idx;
      end
      if (!tok_in.empty && !valid_ff) begin
         tok_in_c.empty     = 1'b1;
         tok_in_c.empty_idx = cell_idx;
      end
      if (!tok_in.min_set || (cnt_ff < tok_in.min_cnt)) begin
         tok_in_c.min_set  = 1'b1;
         tok_in_c.min_cnt  = cnt_ff;
         tok_in_c.min_idx  = cell_idx;
         tok_in_c.min_page = page_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in_c;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         cnt_ff   <= '0;
      end else if (upd_here) begin
         if (upd.fill) begin
            valid_ff <= 1'b1;
            cnt_ff   <= COUNT_BITS'(1);
         end else if (cnt_ff != COUNT_MAX) begin
            cnt_ff <= cnt_ff + COUNT_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (upd_here && upd.fill) begin
         page_ff <= upd.page;
      end
   end

   assign tok_out = tok_ff;

endmodule

// ----- src/lfu_page_replacement.sv -----
// LFU page replacement top level: frame cell chain, sequencer, result register and CSR port.
//
// Each accepted word is one page reference. A search token enters frame cell 0 and moves one
// cell per clock through the active frames, collecting the first hit, the first empty frame and
// the least used frame; the chosen frame is then updated and the result word is loaded into
// the output register. How long one word takes is set by the token's walk along the active
// frames (frames_in_use of 0 counts as one frame, above eight as eight), plus any time a still
// waiting result holds the commit back; the next word is taken while a result still waits.
// frames_in_use (byte address 0) may only be written while the block is idle.
module lfu_page_replacement (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [lfu_pkg::PAGE_NUMBER_W-1:0]    req_page_number,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_fault,
   output logic [lfu_pkg::FRAME_INDEX_W-1:0]    rsp_frame_index,
   output logic                                 rsp_evicted,
   output logic [lfu_pkg::EVICTED_PAGE_W-1:0]   rsp_evicted_page,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [lfu_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [lfu_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [lfu_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                                 csr_pready
);
   import lfu_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SEARCH = 2'd1;
   localparam logic [1:0] ST_COMMIT = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [CFG_BITS-1:0]   cfg_ff;
   logic [IDX_BITS-1:0]   lim_idx;
   search_type            inj_ff;
   search_type            tok_out [FRAMES];
   search_type            done_tok;
   update_type            upd;
   logic [FRAMES-1:0]     chain_vld;
   logic                  req_fire, done, commit_go, csr_wr;

   logic                  dec_fault_ff, dec_evict_ff;
   logic [IDX_BITS-1:0]   dec_slot_ff;
   logic [PAGE_BITS-1:0]  dec_page_ff, dec_evpage_ff;

   logic                      rsp_valid_ff;
   logic                      rsp_fault_ff, rsp_evicted_ff;
   logic [FRAME_INDEX_W-1:0]  rsp_frame_index_ff;
   logic [EVICTED_PAGE_W-1:0] rsp_evicted_page_ff;

   // CSR port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[CSR_ADDR_BITS-1] == REG_FRAMES_IN_USE);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_wr) begin
         cfg_ff <= csr_pwdata[CFG_BITS-1:0];
      end
   end

   always_comb begin
      if (csr_paddr[CSR_ADDR_BITS-1] == REG_FRAMES_IN_USE) begin
         csr_prdata = CSR_DATA_BITS'(cfg_ff);
      end else begin
         csr_prdata = '0;
      end
   end

   // last active frame
   always_comb begin
      if (cfg_ff == '0) begin
         lim_idx = '0;
      end else if (int'(cfg_ff) > FRAMES) begin
         lim_idx = IDX_BITS'(FRAMES - 1);
      end else begin
         lim_idx = IDX_BITS'(cfg_ff - CFG_BITS'(1));
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      inj_ff.valid     <= !reset && req_fire;
      inj_ff.page      <= PAGE_BITS'(req_page_number);
      inj_ff.hit       <= 1'b0;
      inj_ff.hit_idx   <= '0;
      inj_ff.empty     <= 1'b0;
      inj_ff.empty_idx <= '0;
      inj_ff.min_set   <= 1'b0;
      inj_ff.min_cnt   <= '0;
      inj_ff.min_idx   <= '0;
      inj_ff.min_page  <= '0;
   end

   generate
      for (genvar k = 0; k < FRAMES; k++) begin : g_cell
         lfu_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .cell_idx (IDX_BITS'(k)),
            .cell_on  (IDX_BITS'(k) <= lim_idx),
            .tok_in   ((k == 0) ? inj_ff : tok_out[(k == 0) ? 0 : k - 1]),
            .tok_out  (tok_out[k]),
            .upd      (upd)
         );
         assign chain_vld[k] = tok_out[k].valid;
      end
   endgenerate

   assign done_tok  = tok_out[lim_idx];
   assign done      = (state_ff == ST_SEARCH) && done_tok.valid;
   assign commit_go = (state_ff == ST_COMMIT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_fire) state_in = ST_SEARCH;
         ST_SEARCH: if (done) state_in = ST_COMMIT;
         ST_COMMIT: if (commit_go) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // decision from the finished token
   always_ff @(posedge clock) begin
      if (done) begin
         dec_fault_ff  <= !done_tok.hit;
         dec_evict_ff  <= !done_tok.hit && !done_tok.empty;
         dec_page_ff   <= done_tok.page;
         dec_evpage_ff <= (!done_tok.hit && !done_tok.empty) ? done_tok.min_page : '0;
         priority if (done_tok.hit) begin
            dec_slot_ff <= done_tok.hit_idx;
         end else if (done_tok.empty) begin
            dec_slot_ff <= done_tok.empty_idx;
         end else begin
            dec_slot_ff <= done_tok.min_idx;
         end
      end
   end

   assign upd.en   = commit_go;
   assign upd.fill = dec_fault_ff;
   assign upd.idx  = dec_slot_ff;
   assign upd.page = dec_page_ff;

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit_go) begin
         rsp_fault_ff        <= dec_fault_ff;
         rsp_frame_index_ff  <= FRAME_INDEX_W'(dec_slot_ff);
         rsp_evicted_ff      <= dec_evict_ff;
         rsp_evicted_page_ff <= EVICTED_PAGE_W'(dec_evpage_ff);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_fault        = rsp_fault_ff;
   assign rsp_frame_index  = rsp_frame_index_ff;
   assign rsp_evicted      = rsp_evicted_ff;
   assign rsp_evicted_page = rsp_evicted_page_ff;

   // checks
   a_evict_is_fault: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_evicted |-> rsp_fault)
      else $error("eviction reported without fault");

   a_evpage_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_evicted |-> rsp_evicted_page == '0)
      else $error("evicted page nonzero without eviction");

   a_idle_chain_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> chain_vld == '0)
      else $error("search token in chain while idle");

   a_commit_loads: assert property (@(posedge clock) disable iff (reset)
      upd.en |=> rsp_valid && state_ff == ST_IDLE)
      else $error("frame update without result");

endmodule
